// ===== hw/rtl/gdod_pkg.sv =====
`default_nettype none
package gdod_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int OFFSET_W  = 20;
    localparam int COUNT_W   = 22;
    localparam int DN_W      = 23;
    localparam int MAX_YEAR  = 9999;
    localparam int FIX_YEAR  = 1900;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // ceil(2^20 / 100): exact quotient by 100 for any 14-bit value
    localparam int RECIP_100 = 10486;

    localparam logic CMD_SHIFT = 1'b0;
    localparam logic CMD_DIFF  = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // century test through the reciprocal of 100; y%400 == 0 is (y/100)%4 == 0
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [27:0] prod;
        logic [7:0]  q;
        logic        cent;
        prod = 28'(y) * 28'(RECIP_100);
        q    = prod[27:20];
        cent = (16'(q) * 16'd100) == 16'(y);
        return (y[1:0] == 2'b00 && !cent) || (cent && q[1:0] == 2'b00);
    endfunction

    function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
                                                       input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd2:                   d = is_leap(y) ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11: d = DAY_W'(30);
            default:                d = DAY_W'(31);
        endcase
        return d;
    endfunction

    // days before month m in a common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    typedef struct packed {
        logic                cmd;
        logic                fixed;
        logic [DN_W-1:0]     na;
        logic [DN_W-1:0]     nb;
        logic signed [OFFSET_W-1:0] offset;
    } dn_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gdod_to_days.sv =====
`default_nettype none
// Date -> day number, three stages: validate, year term, month term.
module gdod_to_days (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    adv,
    input  wire logic                                    in_valid,
    input  wire logic                                    in_cmd,
    input  wire gdod_pkg::date_t                         in_a,
    input  wire gdod_pkg::date_t                         in_b,
    input  wire logic signed [gdod_pkg::OFFSET_W-1:0]    in_offset,
    output logic                                         out_valid,
    output gdod_pkg::dn_t                                out_dn
);
    localparam int YW = gdod_pkg::YEAR_W;
    localparam int DW = gdod_pkg::DN_W;

    logic [2:0] v_reg;

    // stage 1: fixed dates
    logic            cmd1_reg, fixed1_reg;
    gdod_pkg::date_t a1_reg, b1_reg;
    logic signed [gdod_pkg::OFFSET_W-1:0] off1_reg, off2_reg;

    function automatic logic ok(input gdod_pkg::date_t d);
        return d.year != '0 && d.month >= 4'd1 && d.month <= 4'd12 && d.day != '0 &&
               d.day <= gdod_pkg::days_in_month(d.year, d.month);
    endfunction

    gdod_pkg::date_t fa, fb, fix_d;
    logic bad_a, bad_b;
    always_comb
    begin
        fix_d = '{year: YW'(gdod_pkg::FIX_YEAR), month: 4'd1, day: 5'd1};
        bad_a = !ok(in_a);
        bad_b = !ok(in_b) && in_cmd == gdod_pkg::CMD_DIFF;
        fa = bad_a ? fix_d : in_a;
        fb = bad_b ? fix_d : in_b;
    end

    // stage 2: 365*p + p/4 - p/100 + p/400, p/400 taken as (p/100)/4
    function automatic logic [DW-1:0] year_days(input logic [YW-1:0] y);
        logic [YW-1:0] p;
        logic [27:0]   prod;
        logic [7:0]    q100;
        p    = y - YW'(1);
        prod = 28'(p) * 28'(gdod_pkg::RECIP_100);
        q100 = prod[27:20];
        return DW'(p) * DW'(365) + DW'(p >> 2) - DW'(q100) + DW'(q100 >> 2);
    endfunction

    logic            cmd2_reg, fixed2_reg;
    gdod_pkg::date_t a2_reg, b2_reg;
    logic [DW-1:0]   ya2_reg, yb2_reg;

    function automatic logic [DW-1:0] md(input gdod_pkg::date_t d);
        logic [8:0] x;
        x = gdod_pkg::days_before(d.month) + 9'(d.day) - 9'd1;
        if (d.month > 4'd2 && gdod_pkg::is_leap(d.year))
            x = x + 9'd1;
        return DW'(x);
    endfunction

    gdod_pkg::dn_t dn3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg   <= in_cmd;
            fixed1_reg <= bad_a || bad_b;
            a1_reg     <= fa;
            b1_reg     <= fb;
            off1_reg   <= in_offset;

            cmd2_reg   <= cmd1_reg;
            fixed2_reg <= fixed1_reg;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            off2_reg   <= off1_reg;
            ya2_reg    <= year_days(a1_reg.year);
            yb2_reg    <= year_days(b1_reg.year);

            dn3_reg.cmd    <= cmd2_reg;
            dn3_reg.fixed  <= fixed2_reg;
            dn3_reg.na     <= ya2_reg + md(a2_reg);
            dn3_reg.nb     <= yb2_reg + md(b2_reg);
            dn3_reg.offset <= off2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_dn    = dn3_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/gdod_from_days.sv =====
`default_nettype none
// Day number -> date and difference, seven stages.
module gdod_from_days (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire gdod_pkg::dn_t   in_dn,
    output logic                 out_valid,
    output logic [gdod_pkg::YEAR_W-1:0]  res_year,
    output logic [gdod_pkg::MONTH_W-1:0] res_month,
    output logic [gdod_pkg::DAY_W-1:0]   res_day,
    output logic [gdod_pkg::COUNT_W-1:0] day_count,
    output logic                 a_before_b,
    output logic                 a_equals_b,
    output logic                 input_fixed,
    output logic                 out_of_range
);
    localparam int DW = gdod_pkg::DN_W;
    localparam int YW = gdod_pkg::YEAR_W;
    localparam int SW = DW + 2;

    // ceil(2^40 / 146097), exact for any 23-bit day number
    localparam logic [22:0] RECIP_146097 = 23'd7525902;
    // ceil(2^28 / 1461), exact below 146097
    localparam logic [17:0] RECIP_1461   = 18'd183735;

    typedef struct packed {
        logic          cmd;
        logic          fixed;
        logic          bad;
        logic          lt;
        logic          eq;
        logic [DW-1:0] diff;
    } side_t;

    logic [6:0] v_reg;
    side_t      side_reg [1:6];

    // stage 1: shifted day number, difference
    logic signed [SW-1:0] n_next;
    logic [DW-1:0] n1_reg;
    always_comb
        n_next = SW'(signed'({2'b0, in_dn.na})) + SW'(in_dn.offset);

    // stage 2: 400-year cycle count by reciprocal
    logic [45:0]   q_prod;
    logic [5:0]    c400_2_reg;
    logic [DW-1:0] n2_reg;
    always_comb
        q_prod = 46'(n1_reg) * 46'(RECIP_146097);

    // stage 3: remainder within the cycle
    logic [DW-1:0] r400;
    logic [5:0]    c400_3_reg;
    logic [17:0]   r3_reg;
    always_comb
        r400 = n2_reg - DW'(c400_2_reg) * DW'(146097);

    // stage 4: centuries
    logic [1:0]  c100;
    logic [17:0] rc;
    logic [5:0]  c400_4_reg;
    logic [1:0]  c100_4_reg;
    logic [17:0] rc4_reg;
    always_comb
    begin
        c100 = (r3_reg >= 18'd109572) ? 2'd3 : (r3_reg >= 18'd73048) ? 2'd2 :
               (r3_reg >= 18'd36524) ? 2'd1 : 2'd0;
        rc   = r3_reg - 18'(c100) * 18'd36524;
    end

    // stage 5: 4-year groups by reciprocal
    logic [35:0] c4_prod;
    logic [5:0]  c400_5_reg;
    logic [1:0]  c100_5_reg;
    logic [4:0]  c4_5_reg;
    logic [17:0] rc5_reg;
    always_comb
        c4_prod = 36'(rc4_reg) * 36'(RECIP_1461);

    // stage 6: years within the group, year number
    logic [10:0]   r4;
    logic [1:0]    c1;
    logic [8:0]    ry;
    logic [YW+1:0] y_n;
    logic [YW+1:0] y6_reg;
    logic [8:0]    r6_reg;
    always_comb
    begin
        r4   = 11'(rc5_reg - 18'(c4_5_reg) * 18'd1461);
        c1   = (r4 >= 11'd1095) ? 2'd3 : (r4 >= 11'd730) ? 2'd2 :
               (r4 >= 11'd365) ? 2'd1 : 2'd0;
        ry   = 9'(r4 - 11'(c1) * 11'd365);
        y_n  = (YW+2)'(c400_5_reg) * (YW+2)'(400) + (YW+2)'(c100_5_reg) * (YW+2)'(100) +
               (YW+2)'(c4_5_reg) * (YW+2)'(4) + (YW+2)'(c1) + (YW+2)'(1);
    end

    // stage 7: month from day of year, range check, output
    logic [YW-1:0] yt;
    logic [8:0] rr, lb;
    logic [3:0] mo;
    logic lp, bad;
    always_comb
    begin
        yt = YW'(y6_reg);
        lp = gdod_pkg::is_leap(yt);
        mo = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            lb = gdod_pkg::days_before(4'(i)) + ((i > 2 && lp) ? 9'd1 : 9'd0);
            if (r6_reg >= lb)
                mo = 4'(i);
        end
        rr  = r6_reg - gdod_pkg::days_before(mo) - ((mo > 4'd2 && lp) ? 9'd1 : 9'd0);
        bad = side_reg[6].bad || y6_reg > (YW+2)'(gdod_pkg::MAX_YEAR) || y6_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= '{cmd:   in_dn.cmd,
                             fixed: in_dn.fixed,
                             bad:   n_next[SW-1],
                             lt:    in_dn.na < in_dn.nb,
                             eq:    in_dn.na == in_dn.nb,
                             diff:  (in_dn.na > in_dn.nb) ? in_dn.na - in_dn.nb :
                                                            in_dn.nb - in_dn.na};
            for (int i = 2; i <= 6; i++)
                side_reg[i] <= side_reg[i-1];

            n1_reg     <= n_next[SW-1] ? '0 : DW'(n_next);

            c400_2_reg <= q_prod[45:40];
            n2_reg     <= n1_reg;

            c400_3_reg <= c400_2_reg;
            r3_reg     <= 18'(r400);

            c400_4_reg <= c400_3_reg;
            c100_4_reg <= c100;
            rc4_reg    <= rc;

            c400_5_reg <= c400_4_reg;
            c100_5_reg <= c100_4_reg;
            c4_5_reg   <= 5'(c4_prod[35:28]);
            rc5_reg    <= rc4_reg;

            y6_reg     <= y_n;
            r6_reg     <= ry;

            input_fixed <= side_reg[6].fixed;
            if (side_reg[6].cmd == gdod_pkg::CMD_DIFF)
            begin
                res_year     <= '0;
                res_month    <= '0;
                res_day      <= '0;
                out_of_range <= 1'b0;
                day_count    <= (side_reg[6].diff > DW'(gdod_pkg::COUNT_MAX)) ?
                                gdod_pkg::COUNT_MAX : gdod_pkg::COUNT_W'(side_reg[6].diff);
                a_before_b   <= side_reg[6].lt;
                a_equals_b   <= side_reg[6].eq;
            end
            else
            begin
                res_year     <= bad ? '0 : yt;
                res_month    <= bad ? '0 : mo;
                res_day      <= bad ? '0 : 5'(rr + 9'd1);
                out_of_range <= bad;
                day_count    <= '0;
                a_before_b   <= 1'b0;
                a_equals_b   <= 1'b0;
            end
        end
    end

    assign out_valid = v_reg[6];
endmodule
`default_nettype wire

// ===== hw/rtl/gregorian_date_offset_and_difference.sv =====
`default_nettype none
// Gregorian date unit, fully pipelined: ten register stages (three from date to
// day number, seven from day number back to date), one transaction accepted per
// cycle while the output is not stalled.
// The whole pipeline freezes while the output holds an untaken result
// (m_axis_tready low), so nothing is lost or repeated. cmd 0 shifts date A by
// a signed offset; cmd 1 returns |A-B| in days (saturating) with order flags.
// Invalid input dates are replaced by 1900-01-01 and flagged by input_fixed.
module gregorian_date_offset_and_difference (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, LSB first: year_a[13:0], month_a[3:0], day_a[4:0], offset[19:0],
    // year_b[13:0], month_b[3:0], day_b[4:0]; zero pad to 72 bits
    input  wire logic [71:0] s_axis_tdata,
    // tuser: cmd
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, LSB first: res_year[13:0], res_month[3:0], res_day[4:0],
    // day_count[21:0], a_before_b, a_equals_b, input_fixed, out_of_range; pad to 56
    output logic [55:0]      m_axis_tdata
);
    logic adv, mid_valid, out_valid;
    gdod_pkg::date_t a, b;
    gdod_pkg::dn_t dn;
    logic [13:0] ry;
    logic [3:0]  rm;
    logic [4:0]  rd;
    logic [21:0] dc;
    logic lt, eq, fx, oor;

    // advance unless the output register is full and stalled
    assign adv = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign a = '{year: s_axis_tdata[13:0], month: s_axis_tdata[17:14],
                 day: s_axis_tdata[22:18]};
    assign b = '{year: s_axis_tdata[56:43], month: s_axis_tdata[60:57],
                 day: s_axis_tdata[65:61]};

    gdod_to_days u_to (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(s_axis_tvalid), .in_cmd(s_axis_tuser),
        .in_a(a), .in_b(b), .in_offset(s_axis_tdata[42:23]),
        .out_valid(mid_valid), .out_dn(dn)
    );

    gdod_from_days u_from (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(mid_valid), .in_dn(dn), .out_valid(out_valid),
        .res_year(ry), .res_month(rm), .res_day(rd), .day_count(dc),
        .a_before_b(lt), .a_equals_b(eq), .input_fixed(fx), .out_of_range(oor)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'd0, oor, fx, eq, lt, dc, rd, rm, ry};
endmodule
`default_nettype wire

// ===== tb/gdod_checker.sv =====
module gdod_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [55:0] m_axis_tdata,
    output int               errors,
    output int               pending
);
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] count;
        logic        a_before;
        logic        equal;
        logic        fixed;
        logic        oor;
    } date_result_t;

    date_result_t result_q[$];

    function automatic bit leap_year(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint month_days(longint y, longint m);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // invalid dates become 1900-01-01
    function automatic bit sanitize(inout longint y, inout longint m, inout longint d);
        if (y > 0 && m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, m))
            return 0;
        y = gdod_pkg::FIX_YEAR;
        m = 1;
        d = 1;
        return 1;
    endfunction

    // day number, 0001-01-01 is day 0
    function automatic longint day_number(longint y, longint m, longint d);
        longint p;
        longint n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (longint i = 1; i < m; i++)
            n += month_days(y, i);
        return n + d - 1;
    endfunction

    function automatic date_result_t predict_date(logic [71:0] td, logic cmd);
        date_result_t r;
        longint ya, ma, da, yb, mb, db, n, rem, c400, c100, c4, c1, y, mo, na, nb, diff;
        bit fx;
        r  = '0;
        ya = td[13:0];  ma = td[17:14]; da = td[22:18];
        yb = td[56:43]; mb = td[60:57]; db = td[65:61];
        fx = sanitize(ya, ma, da);
        if (cmd == gdod_pkg::CMD_SHIFT) begin
            n = day_number(ya, ma, da) + longint'($signed(td[42:23]));
            if (n < 0) begin
                r.oor = 1;
            end
            else begin
                c400 = n / 146097;
                rem  = n % 146097;
                c100 = rem / 36524;
                if (c100 > 3) c100 = 3;
                rem -= c100 * 36524;
                c4   = rem / 1461;
                rem  = rem % 1461;
                c1   = rem / 365;
                if (c1 > 3) c1 = 3;
                rem -= c1 * 365;
                y    = 400 * c400 + 100 * c100 + 4 * c4 + c1 + 1;
                mo   = 1;
                while (mo < 12 && rem >= month_days(y, mo)) begin
                    rem -= month_days(y, mo);
                    mo++;
                end
                if (y > gdod_pkg::MAX_YEAR) begin
                    r.oor = 1;
                end
                else begin
                    r.year  = 14'(y);
                    r.month = 4'(mo);
                    r.day   = 5'(rem + 1);
                end
            end
        end
        else begin
            if (sanitize(yb, mb, db)) fx = 1;
            na = day_number(ya, ma, da);
            nb = day_number(yb, mb, db);
            diff = na > nb ? na - nb : nb - na;
            r.count    = diff > 4194303 ? 22'h3FFFFF : 22'(diff);
            r.a_before = na < nb;
            r.equal    = na == nb;
        end
        r.fixed = fx;
        return r;
    endfunction

    date_result_t got, want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            errors  <= 0;
            pending <= 0;
            result_q.delete();
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict_date(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{year:     m_axis_tdata[13:0],
                        month:    m_axis_tdata[17:14],
                        day:      m_axis_tdata[22:18],
                        count:    m_axis_tdata[44:23],
                        a_before: m_axis_tdata[45],
                        equal:    m_axis_tdata[46],
                        fixed:    m_axis_tdata[47],
                        oor:      m_axis_tdata[48]};
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, got);
                    errors <= errors + 1;
                end
                else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected y=%0d m=%0d d=%0d cnt=%0d b=%b e=%b f=%b o=%b",
                                 $time, want.year, want.month, want.day, want.count,
                                 want.a_before, want.equal, want.fixed, want.oor);
                        $display("%0t:          actual   y=%0d m=%0d d=%0d cnt=%0d b=%b e=%b f=%b o=%b",
                                 $time, got.year, got.month, got.day, got.count,
                                 got.a_before, got.equal, got.fixed, got.oor);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= result_q.size();
        end
    end

endmodule

// ===== tb/tb_gregorian_date_offset_and_difference.sv =====
module tb_gregorian_date_offset_and_difference;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // year_a, month_a, day_a, offset, year_b, month_b, day_b
    logic        s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;   // res_year, res_month, res_day, day_count, flags
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          quiet_phase;    // no idling on either side
    bit          hold_sink;      // long receiver stall in progress

    gregorian_date_offset_and_difference dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    gdod_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("** gregorian_date_offset_and_difference: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, suppressed in the quiet phase, forced in a hold
    always @(posedge clk)
    begin
        if (!rst_n || hold_sink)
            m_axis_tready <= 0;
        else
            m_axis_tready <= quiet_phase || ($urandom_range(99) >= 15);
    end

    // long hold-off so the pipeline fills and backpressures the sender
    task automatic stall_sink();
        hold_sink = 1;
        repeat (60) @(posedge clk);
        hold_sink = 0;
    endtask

    // one transaction; random idle cycles before it unless in the quiet phase
    task automatic send_date(logic cmd, logic [13:0] ya, logic [3:0] ma, logic [4:0] da,
                             logic [19:0] off, logic [13:0] yb, logic [3:0] mb,
                             logic [4:0] db);
        while (!quiet_phase && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, db, mb, yb, off, da, ma, ya};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // mostly valid dates, sometimes anything the fields hold
    task automatic pick_date(output logic [13:0] y, output logic [3:0] m,
                             output logic [4:0] d);
        int k;
        k = $urandom_range(99);
        if (k < 10)
        begin
            y = 14'($urandom_range(16383));
            m = 4'($urandom_range(15));
            d = 5'($urandom_range(31));
        end
        else
        begin
            y = (k < 70) ? 14'($urandom_range(2400, 1600)) : 14'($urandom_range(9999, 1));
            m = 4'($urandom_range(12, 1));
            d = (k < 85) ? 5'($urandom_range(28, 1)) : 5'($urandom_range(31, 28));
        end
    endtask

    task automatic send_random();
        logic [13:0] ya, yb;
        logic [3:0]  ma, mb;
        logic [4:0]  da, db;
        logic [19:0] off;
        int k;
        pick_date(ya, ma, da);
        pick_date(yb, mb, db);
        k = $urandom_range(99);
        if (k < 40)      off = 20'($signed($urandom_range(800)) - 400);
        else if (k < 70) off = 20'($signed($urandom_range(80000)) - 40000);
        else             off = 20'($urandom);
        send_date(1'($urandom_range(1)), ya, ma, da, off, yb, mb, db);
    endtask

    initial
    begin
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = gdod_pkg::CMD_SHIFT;
        quiet_phase   = 0;
        hold_sink     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, leap rules, invalid dates, range exits, borrows
        send_date(gdod_pkg::CMD_SHIFT, 14'd2000, 4'd2, 5'd28, 20'd1, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd1900, 4'd2, 5'd29, 20'd0, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd2100, 4'd3, 5'd1, -20'sd1, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd2024, 4'd3, 5'd1, -20'sd400, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd1, 4'd1, 5'd1, -20'sd1, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd9999, 4'd12, 5'd31, 20'd1, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd9999, 4'd12, 5'd31, 20'h80000, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd1, 4'd1, 5'd1, 20'h7FFFF, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'h3FFF, 4'd15, 5'd31, 20'hFFFFF,
                  14'h3FFF, 4'd15, 5'd31);
        send_date(gdod_pkg::CMD_SHIFT, 14'd0, 4'd0, 5'd0, 20'd0, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'h3FFF, 4'd12, 5'd31, 20'd0, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_SHIFT, 14'd2023, 4'd4, 5'd31, 20'd5, 14'd0, 4'd0, 5'd0);
        send_date(gdod_pkg::CMD_DIFF, 14'd2000, 4'd1, 5'd1, 20'd0, 14'd2000, 4'd1, 5'd1);
        send_date(gdod_pkg::CMD_DIFF, 14'd1, 4'd1, 5'd1, 20'd0, 14'd9999, 4'd12, 5'd31);
        send_date(gdod_pkg::CMD_DIFF, 14'h3FFF, 4'd12, 5'd31, 20'd0, 14'd1, 4'd1, 5'd1);
        send_date(gdod_pkg::CMD_DIFF, 14'd1, 4'd1, 5'd1, 20'd0, 14'h3FFF, 4'd12, 5'd31);
        send_date(gdod_pkg::CMD_DIFF, 14'd2001, 4'd2, 5'd29, 20'd0, 14'd1900, 4'd1, 5'd1);
        send_date(gdod_pkg::CMD_DIFF, 14'd1900, 4'd1, 5'd1, 20'd0, 14'd2000, 4'd13, 5'd0);
        send_date(gdod_pkg::CMD_DIFF, 14'd2004, 4'd2, 5'd29, 20'd0, 14'd2004, 4'd3, 5'd1);
        send_date(gdod_pkg::CMD_DIFF, 14'd0, 4'd15, 5'd31, 20'hFFFFF,
                  14'h3FFF, 4'd15, 5'd31);

        // back-to-back stretch, then a sink hold-off while the source keeps offering
        quiet_phase = 1;
        repeat (60) send_random();
        quiet_phase = 0;
        fork
            stall_sink();
            repeat (30) send_random();
        join

        // drain pause
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        repeat (340) send_random();
        s_axis_tvalid <= 0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** gregorian_date_offset_and_difference: PASSED **");
        else
            $display("** gregorian_date_offset_and_difference: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/gdod_pkg.sv
hw/rtl/gdod_to_days.sv
hw/rtl/gdod_from_days.sv
hw/rtl/gregorian_date_offset_and_difference.sv
tb/gdod_checker.sv
tb/tb_gregorian_date_offset_and_difference.sv
